// ===== rtl/plru_pkg.sv =====
package plru_pkg;

    // field widths, fixed by the item format
    localparam int AGE_W     = 4;
    localparam int WAY_W     = 4;
    localparam int SET_IN_W  = 11;
    localparam int MASK_W    = 16;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PART_EN       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_BOUNDARY = 1'd1;

    localparam logic [WAY_W-1:0] BOUNDARY_RST = 4'd15;

    // request kinds
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CALC
    } t_state;

    typedef struct packed {
        logic                op;
        logic [WAY_W-1:0]    way;
        logic                requester;
        logic [MASK_W-1:0]   valid_mask;
        logic                is_writeback;
        logic                hit;
    } t_item;

endpackage

// ===== rtl/partitioned_lru_replacement_core.sv =====
// True-LRU replacement unit for a set-associative cache with optional way
// partitioning between two requesters. Every set holds a 4-bit age per way
// (0 newest) in one synchronous RAM of SETS words, WAYS*4 bits wide. A victim
// request returns the lowest invalid candidate way, or else the oldest
// candidate (lowest index on a tie); it produces one response. An update
// request makes the touched way newest and ages the younger candidate ways;
// a write-back hit or a way beyond WAYS leaves the state alone and no update
// produces a response. With partitioning on, requester 0 owns the ways below
// the boundary and requester 1 the rest; an empty partition falls back to all
// ways. After reset the core writes the initial ages (way i has age i) into
// every RAM word in turn, with s_axis_tready low; configuration writes are
// taken throughout. With a plain-mask set index, the cycle of acceptance
// issues the RAM read and the next one evaluates the set and writes back or
// loads the response register. When SETS is neither a power of two nor above
// 2047 the set index is instead reduced modulo SETS in three steps
// (reciprocal multiplication, back-multiply and subtract, final
// compare-and-subtract), followed by a separate RAM read cycle before the
// evaluation. A response left unaccepted on the master side holds a following
// victim request in its evaluation cycle until the response register is free.
module partitioned_lru_replacement_core #(
    parameter int WAYS = 16,
    parameter int SETS = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [plru_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [plru_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    // request side
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [10:0] set_index, [14:11] way, [15] requester, [31:16] valid_mask,
    // [32] is_writeback, [33] hit, [39:34] zero
    input  logic [plru_pkg::S_DATA_W-1:0]         s_axis_tdata,
    // [0] op
    input  logic                                  s_axis_tuser,
    // response side
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [3:0] victim_way, [7:4] zero
    output logic [plru_pkg::M_DATA_W-1:0]         m_axis_tdata,
    // [0] victim_was_invalid
    output logic                                  m_axis_tuser
);
    import plru_pkg::*;

    localparam int MEM_W     = WAYS * AGE_W;
    localparam int AW        = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SPAN      = 1 << SET_IN_W;
    localparam bit POW2      = (SETS & (SETS - 1)) == 0;
    localparam bit DIRECT    = POW2 || (SETS >= SPAN);
    localparam logic [16:0] SET_MASK = (SETS >= SPAN) ? 17'h1FFFF : 17'(SETS - 1);
    // modulo unit: the reciprocal estimate of the quotient is low by at most
    // one, so a single compare-and-subtract finishes the remainder
    localparam int RECIP_SH  = 2 * SET_IN_W;
    localparam logic [31:0]         RECIP   = 32'((1 << RECIP_SH) / SETS);
    localparam logic [SET_IN_W-1:0] SETS_IN = SET_IN_W'(SETS);
    localparam int RK_W      = 2;
    localparam logic [RK_W-1:0] RK_QUO = 2'd2;
    localparam logic [RK_W-1:0] RK_REM = 2'd1;
    localparam logic [RK_W-1:0] RK_FIX = 2'd0;
    localparam logic [RK_W-1:0] RK_TOP = RK_QUO;
    localparam logic [AW-1:0]   LAST_SET = AW'(SETS - 1);

    function automatic logic [MEM_W-1:0] reset_word();
        logic [MEM_W-1:0] word;
        word = '0;
        for (int w = 0; w < WAYS; w++) begin
            word[w*AGE_W +: AGE_W] = AGE_W'(w);
        end
        return word;
    endfunction

    localparam logic [MEM_W-1:0] RESET_WORD = reset_word();

    // ---------------------------------------------------------------- state
    logic [MEM_W-1:0] mem [SETS];
    logic [MEM_W-1:0] r_rd_word;

    t_state            r_state, n_state;
    t_item             r_item;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_clr;
    logic [SET_IN_W-1:0] r_set;
    logic [SET_IN_W-1:0] r_quo;
    logic [RK_W-1:0]   r_rk;
    logic              r_part_en;
    logic [WAY_W-1:0]  r_boundary;
    logic              r_out_valid;
    logic [WAY_W-1:0]  r_out_way;
    logic              r_out_inv;

    // ------------------------------------------------- request unpacking
    t_item               in_item;
    logic [SET_IN_W-1:0] in_set;
    logic                in_accept;

    assign in_set                 = s_axis_tdata[10:0];
    assign in_item.op             = s_axis_tuser;
    assign in_item.way            = s_axis_tdata[14:11];
    assign in_item.requester      = s_axis_tdata[15];
    assign in_item.valid_mask     = s_axis_tdata[31:16];
    assign in_item.is_writeback   = s_axis_tdata[32];
    assign in_item.hit            = s_axis_tdata[33];
    assign in_accept              = s_axis_tvalid && s_axis_tready;

    // power-of-two or large SETS: index is a plain mask
    logic [AW-1:0] in_addr;
    assign in_addr = AW'(17'(in_set) & SET_MASK);

    // ------------------------------------------------------ configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_en  <= 1'b0;
            r_boundary <= BOUNDARY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PART_EN:       r_part_en  <= i_cfg_data[0];
                CFG_PART_BOUNDARY: r_boundary <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // --------------------------------------------------------- modulo unit
    logic [31:0]         mod_prod;
    logic [SET_IN_W-1:0] mod_quo;
    logic [SET_IN_W-1:0] mod_qs;
    logic [SET_IN_W-1:0] mod_rem;
    logic [SET_IN_W-1:0] mod_fix;

    assign mod_prod = 32'(r_set) * RECIP;
    assign mod_quo  = SET_IN_W'(mod_prod >> RECIP_SH);
    assign mod_qs   = r_quo * SETS_IN;
    assign mod_rem  = r_set - mod_qs;
    assign mod_fix  = (r_set >= SETS_IN) ? r_set - SETS_IN : r_set;

    // ------------------------------------------------------ set evaluation
    logic [AGE_W-1:0] age [WAYS];
    logic [4:0]       cand_lo, cand_hi;
    logic [WAYS-1:0]  cand;
    logic [WAYS-1:0]  invalid;
    logic [WAYS-1:0]  oldest;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] old_way;
    logic             any_inv;
    logic [AGE_W-1:0] touch_age;
    logic             way_ok;
    logic             do_write_upd;
    logic [MEM_W-1:0] upd_word;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            age[w] = r_rd_word[w*AGE_W +: AGE_W];
        end
    end

    // candidate ways [lo, hi); empty partition falls back to all ways
    always_comb begin
        cand_lo = '0;
        cand_hi = 5'(WAYS);
        if (r_part_en) begin
            if (!r_item.requester) begin
                if (r_boundary != '0 && 5'(r_boundary) < 5'(WAYS)) begin
                    cand_hi = 5'(r_boundary);
                end
            end else begin
                if (5'(r_boundary) < 5'(WAYS)) begin
                    cand_lo = 5'(r_boundary);
                end
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            cand[w] = (5'(w) >= cand_lo) && (5'(w) < cand_hi);
        end
    end

    // lowest invalid candidate
    always_comb begin
        invalid = cand & ~r_item.valid_mask[WAYS-1:0];
        any_inv = |invalid;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (invalid[w]) begin
                inv_way = WAY_W'(w);
            end
        end
    end

    // oldest candidate: pairwise compare matrix, lower index wins a tie
    always_comb begin
        old_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            oldest[w] = cand[w];
            for (int v = 0; v < WAYS; v++) begin
                if (v < w) begin
                    if (cand[v] && !(age[w] > age[v])) begin
                        oldest[w] = 1'b0;
                    end
                end else if (v > w) begin
                    if (cand[v] && !(age[w] >= age[v])) begin
                        oldest[w] = 1'b0;
                    end
                end
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (oldest[w]) begin
                old_way = old_way | WAY_W'(w);
            end
        end
    end

    // age update
    always_comb begin
        way_ok    = 5'(r_item.way) < 5'(WAYS);
        touch_age = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_item.way == WAY_W'(w)) begin
                touch_age = age[w];
            end
        end
        upd_word = r_rd_word;
        for (int w = 0; w < WAYS; w++) begin
            if (r_item.way == WAY_W'(w)) begin
                upd_word[w*AGE_W +: AGE_W] = '0;
            end else if (cand[w] && age[w] < touch_age) begin
                upd_word[w*AGE_W +: AGE_W] = age[w] + AGE_W'(1);
            end
        end
        do_write_upd = (r_item.op == OP_UPDATE) && way_ok &&
                       !(r_item.is_writeback && r_item.hit);
    end

    // --------------------------------------------------------- sequencing
    logic calc_stall;
    assign calc_stall = (r_item.op == OP_VICTIM) && r_out_valid && !m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == LAST_SET) n_state = S_IDLE;
            S_IDLE: begin
                if (in_accept) n_state = DIRECT ? S_CALC : S_MOD;
            end
            S_MOD:   if (r_rk == RK_FIX) n_state = S_READ;
            S_READ:  n_state = S_CALC;
            S_CALC:  if (!calc_stall) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MEM_W-1:0] wr_word;
    logic          load_out;

    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = r_addr;
        wr_en         = 1'b0;
        wr_addr       = r_addr;
        wr_word       = upd_word;
        load_out      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_word = RESET_WORD;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                rd_en         = s_axis_tvalid && DIRECT;
                rd_addr       = in_addr;
            end
            S_MOD: ;
            S_READ: rd_en = 1'b1;
            S_CALC: begin
                wr_en    = do_write_upd;
                load_out = (r_item.op == OP_VICTIM) && !calc_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // request registers and modulo working values
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= in_item;
            r_set  <= in_set;
            r_rk   <= RK_TOP;
            r_addr <= in_addr;
        end else if (r_state == S_MOD) begin
            r_rk <= r_rk - RK_W'(1);
            unique case (r_rk)
                RK_QUO:  r_quo  <= mod_quo;
                RK_REM:  r_set  <= mod_rem;
                default: r_addr <= AW'(mod_fix);
            endcase
        end
    end

    // age RAM
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_word <= mem[rd_addr];
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_way <= any_inv ? inv_way : old_way;
            r_out_inv <= any_inv;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - WAY_W){1'b0}}, r_out_way};
    assign m_axis_tuser  = r_out_inv;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Way-partitioned true-LRU replacement core: stream-level regression.
// A directed table comes first, then random traffic over several partition
// settings. Every accepted request is run through a local age model; each
// victim response is compared with the oldest outstanding expected victim.
module tb_top;
    import plru_pkg::*;

    localparam int NUM_WAYS = 16;
    localparam int NUM_SETS = 2048;
    localparam int PHASE_LEN = 200;

    typedef struct packed {
        logic                  op;
        logic [SET_IN_W-1:0]   set_index;
        logic [WAY_W-1:0]      way;
        logic                  requester;
        logic [MASK_W-1:0]     valid_mask;
        logic                  is_writeback;
        logic                  hit;
    } t_request;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic             was_invalid;
    } t_victim;

    // a table row is either a request or a pair of register writes
    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_request         req;
        logic             part_en;
        logic [WAY_W-1:0] boundary;
        logic             fixed;    // expected victim typed in below
        t_victim          victim;
    } t_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_PART_EN;
    logic [CFG_DAT_W-1:0]  i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_VICTIM;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;

    // age model: nibble i of each word is the age of way i
    logic [63:0]       lru_ages [NUM_SETS];
    logic              model_part_en;
    logic [WAY_W-1:0]  model_boundary;

    t_victim     victim_q [$];
    t_row        dir_rows [$];
    bit          no_stall = 1'b0;
    int unsigned fault_count = 0;

    partitioned_lru_replacement_core #(
        .WAYS (NUM_WAYS),
        .SETS (NUM_SETS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // generous ceiling on run time, covering the clearing pass and every request
    initial begin
        #400000;
        $display("partitioned_lru_replacement_core regression: fail");
        $finish;
    end

    // response side back-pressure, switched off during the steady phase
    always @(negedge i_clk) begin
        m_axis_tready <= no_stall || ($urandom_range(99) >= 26);
    end

    // Victim search and age update on the local copy. Returns 1 when the
    // request produces a response.
    function automatic bit predict_request(input t_request r, output t_victim v);
        int          lo;
        int          hi;
        int          w;
        int          best;
        int          best_age;
        logic [3:0]  a;
        logic [3:0]  touched;
        logic [63:0] ages;
        lo = 0;
        hi = NUM_WAYS;
        // partition window; an empty partition falls back to every way
        if (model_part_en) begin
            if (r.requester == 1'b0) begin
                if (model_boundary != 0)
                    hi = int'(model_boundary);
            end else begin
                lo = int'(model_boundary);
            end
        end
        ages = lru_ages[r.set_index];
        v = '0;
        if (r.op == OP_VICTIM) begin
            for (w = lo; w < hi; w++) begin
                if (!r.valid_mask[w]) begin
                    v.way = WAY_W'(w);
                    v.was_invalid = 1'b1;
                    return 1'b1;
                end
            end
            best = lo;
            best_age = -1;
            for (w = lo; w < hi; w++) begin
                a = ages[4*w +: 4];
                if (int'(a) > best_age) begin
                    best = w;
                    best_age = int'(a);
                end
            end
            v.way = WAY_W'(best);
            return 1'b1;
        end
        // write-back hits leave the ages untouched
        if (r.is_writeback && r.hit)
            return 1'b0;
        touched = ages[4*r.way +: 4];
        for (w = lo; w < hi; w++) begin
            a = ages[4*w +: 4];
            if (a < touched)
                ages[4*w +: 4] = a + 4'd1;
        end
        ages[4*r.way +: 4] = 4'd0;
        lru_ages[r.set_index] = ages;
        return 1'b0;
    endfunction

    function automatic void add_req(input logic op, input int set_index, input int way,
                                    input logic requester, input logic [15:0] mask,
                                    input logic wb, input logic hit, input logic fixed,
                                    input int exp_way, input logic exp_invalid);
        t_row row;
        row = '0;
        row.kind = ROW_REQ;
        row.req = '{op, set_index[SET_IN_W-1:0], way[WAY_W-1:0], requester, mask, wb, hit};
        row.fixed = fixed;
        row.victim = '{exp_way[WAY_W-1:0], exp_invalid};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic part_en, input int boundary);
        t_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.part_en = part_en;
        row.boundary = boundary[WAY_W-1:0];
        dir_rows.push_back(row);
    endfunction

    // Random request. Most traffic lands on a handful of hot sets so that
    // ages get churned deeply; the rest spreads over the whole index range.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.op = ($urandom_range(1) == 0) ? OP_VICTIM : OP_UPDATE;
        pick = $urandom_range(99);
        if (pick < 75) begin
            case ($urandom_range(5))
                0: r.set_index = 11'd0;
                1: r.set_index = 11'd1;
                2: r.set_index = 11'd1024;
                3: r.set_index = 11'd2047;
                4: r.set_index = 11'd1365;
                default: r.set_index = 11'd682;
            endcase
        end else begin
            r.set_index = SET_IN_W'($urandom_range(NUM_SETS - 1));
        end
        r.way = WAY_W'($urandom_range(NUM_WAYS - 1));
        r.requester = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 55)
            r.valid_mask = 16'hFFFF;
        else if (pick < 80)
            r.valid_mask = ~(16'h0001 << $urandom_range(15));
        else
            r.valid_mask = MASK_W'($urandom_range(16'hFFFF));
        r.is_writeback = 1'($urandom_range(1));
        r.hit = 1'($urandom_range(1));
        return r;
    endfunction

    // Present one request, hold it until accepted, then predict.
    task automatic send_request(input t_request r, input logic fixed, input t_victim typed_v);
        int      gap;
        t_victim v;
        gap = 0;
        while (!no_stall && $urandom_range(99) < 26 && gap < 8) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            gap++;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {6'b0, r.hit, r.is_writeback, r.valid_mask, r.requester,
                          r.way, r.set_index};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_request(r, v))
            victim_q.push_back(fixed ? typed_v : v);
    endtask

    // Wait for the core to go quiet, then write both registers.
    task automatic apply_config(input logic part_en, input logic [WAY_W-1:0] boundary);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (victim_q.size() != 0)
            @(posedge i_clk);
        // a trailing update may still be in its write-back cycle
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PART_EN;
        i_cfg_data  <= {{(CFG_DAT_W-1){1'b0}}, part_en};
        @(negedge i_clk);
        i_cfg_index <= CFG_PART_BOUNDARY;
        i_cfg_data  <= boundary;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_part_en  = part_en;
        model_boundary = boundary;
    endtask

    // response check
    always @(posedge i_clk) begin
        t_victim exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (victim_q.size() == 0) begin
                $error("unexpected response: victim_way %0d victim_was_invalid %0b",
                       m_axis_tdata[3:0], m_axis_tuser);
                fault_count++;
            end else begin
                exp_v = victim_q.pop_front();
                if (m_axis_tdata[3:0] !== exp_v.way) begin
                    $error("victim_way: expected %0d, got %0d", exp_v.way, m_axis_tdata[3:0]);
                    fault_count++;
                end
                if (m_axis_tuser !== exp_v.was_invalid) begin
                    $error("victim_was_invalid: expected %0b, got %0b",
                           exp_v.was_invalid, m_axis_tuser);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        int              s;
        int              w;
        int              p;
        logic [WAY_W-1:0] bnd;
        for (s = 0; s < NUM_SETS; s++)
            for (w = 0; w < NUM_WAYS; w++)
                lru_ages[s][4*w +: 4] = 4'(w);
        model_part_en  = 1'b0;
        model_boundary = BOUNDARY_RST;

        // Directed table. Fixed rows rely on the reset ages (way i has age i)
        // of sets not yet touched.
        add_cfg(1'b0, 15);
        add_req(OP_VICTIM, 0,    0,  1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 15, 1'b0);
        add_req(OP_VICTIM, 2047, 15, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 0,  1'b1);
        add_req(OP_VICTIM, 5,    0,  1'b0, 16'h7FFF, 1'b0, 1'b1, 1'b1, 15, 1'b1);
        add_req(OP_VICTIM, 5,    0,  1'b1, 16'hFFFE, 1'b1, 1'b0, 1'b1, 0,  1'b1);
        add_req(OP_UPDATE, 0,    15, 1'b0, 16'hFFFF, 1'b0, 1'b1, 1'b0, 0,  1'b0);
        add_req(OP_VICTIM, 0,    0,  1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        // write-back hit: ages must not move
        add_req(OP_UPDATE, 0,    3,  1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 0,  1'b0);
        add_req(OP_VICTIM, 0,    0,  1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        add_req(OP_UPDATE, 0,    0,  1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 0,  1'b0);
        add_req(OP_UPDATE, 0,    9,  1'b1, 16'h5555, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        add_req(OP_VICTIM, 0,    0,  1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        // narrowest partition for requester 0
        add_cfg(1'b1, 1);
        add_req(OP_VICTIM, 10,   0,  1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 0,  1'b0);
        add_req(OP_VICTIM, 10,   0,  1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 15, 1'b0);
        add_req(OP_VICTIM, 10,   0,  1'b1, 16'h0001, 1'b0, 1'b0, 1'b1, 1,  1'b1);
        // touch a way outside the requester's partition
        add_req(OP_UPDATE, 10,   0,  1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0, 0,  1'b0);
        add_req(OP_VICTIM, 10,   0,  1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        // widest partition for requester 0
        add_cfg(1'b1, 15);
        add_req(OP_VICTIM, 20,   0,  1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 15, 1'b0);
        add_req(OP_VICTIM, 20,   0,  1'b0, 16'h7FFF, 1'b0, 1'b0, 1'b1, 14, 1'b0);
        add_req(OP_UPDATE, 20,   15, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        add_req(OP_VICTIM, 20,   0,  1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0, 0,  1'b0);
        // requester 0 owns nothing: falls back to all ways
        add_cfg(1'b1, 0);
        add_req(OP_VICTIM, 30,   0,  1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 15, 1'b0);
        add_req(OP_VICTIM, 30,   0,  1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 15, 1'b0);
        add_req(OP_VICTIM, 30,   0,  1'b0, 16'hEFFF, 1'b0, 1'b0, 1'b1, 12, 1'b1);

        // synchronous reset, released on a falling clock edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                apply_config(dir_rows[i].part_en, dir_rows[i].boundary);
            else
                send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].victim);
        end

        // random phases, one partition setting each; phase 3 runs without stalls
        for (p = 0; p < 7; p++) begin
            case (p)
                0: apply_config(1'b0, 4'd15);
                1: apply_config(1'b1, 4'd1);
                2: apply_config(1'b1, 4'd15);
                3: apply_config(1'b1, 4'd8);
                4: apply_config(1'b1, 4'd0);
                5: begin
                    bnd = WAY_W'($urandom_range(14, 2));
                    apply_config(1'b1, bnd);
                end
                default: begin
                    bnd = WAY_W'($urandom_range(15));
                    apply_config(1'b0, bnd);
                end
            endcase
            no_stall = (p == 3);
            repeat (PHASE_LEN)
                send_request(random_request(), 1'b0, '0);
            no_stall = 1'b0;
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (victim_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("partitioned_lru_replacement_core regression: pass");
        else
            $display("partitioned_lru_replacement_core regression: fail");
        $finish;
    end

endmodule
